// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the character LCD sequencer RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// An implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`endif

// ===== hw/rtl/clns_pkg.sv =====
// Package for the character LCD nibble sequencer: widths, codes, init table,
// state types and the phase search functions. Depends on nothing.
package clns_pkg;

  localparam int CNT_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 4;
  localparam int BYTE_W    = 8;
  localparam int NIB_W     = 4;
  localparam int CMD_W     = 2;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SETUP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STROBE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LONG   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POWER  = 3'd6;

  localparam logic [CFG_W-1:0] RST_SETUP  = 16'd5;
  localparam logic [CFG_W-1:0] RST_STROBE = 16'd5;
  localparam logic [CFG_W-1:0] RST_HOLD   = 16'd5;
  localparam logic [CFG_W-1:0] RST_GAP    = 16'd20;
  localparam logic [CFG_W-1:0] RST_SHORT  = 16'd40;
  localparam logic [CFG_W-1:0] RST_LONG   = 16'd2000;
  localparam logic [CFG_W-1:0] RST_POWER  = 16'd15000;

  localparam logic [BYTE_W-1:0] BYTE_CLEAR = 8'h01;
  localparam logic [BYTE_W-1:0] BYTE_HOME  = 8'h02;

  localparam logic [STEP_W-1:0] STEP_WRITE      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_FIRST      = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LAST_NIB   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_FIRST_BYTE = 4'd4;
  localparam logic [STEP_W-1:0] STEP_LAST       = 4'd8;

  // Items of the power-up sequence; entry 0 is unused.
  localparam logic [BYTE_W-1:0] INIT_ITEMS [0:8] = '{
    8'h00, 8'h03, 8'h03, 8'h02, 8'h28, 8'h06, 8'h0C, 8'h01, 8'h02
  };

  // Phases in the order they run within one item. POS_DONE marks a finished
  // item during the search and is never stored.
  typedef enum logic [3:0] {
    POS_IDLE, POS_POWER, POS_S1, POS_T1, POS_H1, POS_S2, POS_T2, POS_H2,
    POS_GAP, POS_EXTRA, POS_DONE
  } pos_t;

  typedef struct packed {
    logic [CFG_W-1:0] setup;
    logic [CFG_W-1:0] strobe;
    logic [CFG_W-1:0] hold;
    logic [CFG_W-1:0] gap;
    logic [CFG_W-1:0] short_cmd;
    logic [CFG_W-1:0] long_cmd;
    logic [CFG_W-1:0] power;
  } cfg_t;

  typedef struct packed {
    pos_t              pos;
    logic [STEP_W-1:0] step;
    logic [BYTE_W-1:0] hbyte;
    logic [NIB_W-1:0]  nib;
    logic [CNT_W-1:0]  cnt;
  } seq_state_t;

  function automatic logic is_nib_item(logic [STEP_W-1:0] step);
    return (step >= STEP_FIRST) && (step <= STEP_LAST_NIB);
  endfunction

  function automatic logic [BYTE_W-1:0] item_byte(logic [STEP_W-1:0] step,
                                                  logic [BYTE_W-1:0] hbyte);
    logic [BYTE_W-1:0] b;
    b = hbyte;
    if ((step >= STEP_FIRST_BYTE) && (step <= STEP_LAST)) begin
      b = INIT_ITEMS[step];
    end
    return b;
  endfunction

  function automatic logic [CNT_W-1:0] extra_ticks(cfg_t cfg, logic [BYTE_W-1:0] b);
    return ((b == BYTE_CLEAR) || (b == BYTE_HOME)) ? cfg.long_cmd : cfg.short_cmd;
  endfunction

  function automatic logic [CNT_W-1:0] stop_ticks(cfg_t cfg, pos_t p,
                                                 logic [BYTE_W-1:0] b);
    logic [CNT_W-1:0] t;
    case (p)
      POS_POWER: t = cfg.power;
      POS_S1, POS_S2: t = cfg.setup;
      POS_T1, POS_T2: t = cfg.strobe;
      POS_H1, POS_H2: t = cfg.hold;
      POS_GAP: t = cfg.gap;
      POS_EXTRA: t = extra_ticks(cfg, b);
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic pos_t next_entry(pos_t p);
    pos_t n;
    case (p)
      POS_S1: n = POS_T1;
      POS_T1: n = POS_H1;
      POS_H1: n = POS_S2;
      POS_S2: n = POS_T2;
      POS_T2: n = POS_H2;
      POS_H2: n = POS_GAP;
      POS_GAP: n = POS_EXTRA;
      default: n = POS_DONE;
    endcase
    return n;
  endfunction

  // First phase at or after entry, within one item, that the item uses and whose count is not zero.
  function automatic pos_t first_stop(cfg_t cfg, pos_t entry, logic nib_item,
                                      logic has_x, logic [BYTE_W-1:0] b);
    pos_t p;
    pos_t found;
    logic hit;
    logic usable;
    found = POS_DONE;
    hit = 1'b0;
    for (int k = int'(POS_S1); k <= int'(POS_EXTRA); k++) begin
      p = pos_t'(k[3:0]);
      usable = 1'b1;
      if (nib_item && ((p == POS_S2) || (p == POS_T2) || (p == POS_H2))) begin
        usable = 1'b0;
      end
      if ((p == POS_EXTRA) && !has_x) begin
        usable = 1'b0;
      end
      if (!hit && usable && (p >= entry) && (stop_ticks(cfg, p, b) != '0)) begin
        hit = 1'b1;
        found = p;
      end
    end
    return found;
  endfunction

  function automatic logic [NIB_W-1:0] nibble_for(pos_t p, logic [STEP_W-1:0] step,
                                                  logic [BYTE_W-1:0] b);
    logic [NIB_W-1:0] n;
    if (is_nib_item(step)) begin
      n = INIT_ITEMS[step][3:0];
    end else if ((p == POS_S1) || (p == POS_T1) || (p == POS_H1)) begin
      n = b[7:4];
    end else begin
      n = b[3:0];
    end
    return n;
  endfunction

  // Runs through phases and items whose counts are zero until a phase with a
  // nonzero count is entered or the sequence ends.
  function automatic seq_state_t seek(cfg_t cfg, logic [STEP_W-1:0] step, pos_t entry,
                                      logic [BYTE_W-1:0] hbyte, logic sel);
    logic [BYTE_W-1:0] b;
    logic              nib_item;
    logic              hit;
    logic [STEP_W-1:0] js;
    pos_t              p;
    seq_state_t        s;
    b = item_byte(step, hbyte);
    nib_item = is_nib_item(step);
    p = first_stop(cfg, entry, nib_item, !nib_item && !sel, b);
    s.pos = p;
    s.step = step;
    s.hbyte = b;
    if (p == POS_DONE) begin
      s.pos = POS_IDLE;
      s.step = STEP_WRITE;
      s.hbyte = (step != STEP_WRITE) ? INIT_ITEMS[STEP_LAST] : b;
      hit = 1'b0;
      if ((step >= STEP_FIRST) && (step < STEP_LAST)) begin
        for (int j = 1; j <= int'(STEP_LAST); j++) begin
          js = j[STEP_W-1:0];
          if (!hit && (js > step)) begin
            b = item_byte(js, hbyte);
            nib_item = is_nib_item(js);
            p = first_stop(cfg, POS_S1, nib_item, !nib_item, b);
            if (p != POS_DONE) begin
              hit = 1'b1;
              s.pos = p;
              s.step = js;
              s.hbyte = b;
            end
          end
        end
      end
    end
    s.nib = nibble_for(s.pos, s.step, s.hbyte);
    s.cnt = stop_ticks(cfg, s.pos, s.hbyte);
    return s;
  endfunction

endpackage

// ===== hw/rtl/clns_if.sv =====
// Valid/ready channel interfaces for the LCD sequencer: tick requests in,
// pin levels out. Depends on clns_pkg.
interface clns_in_if import clns_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic              is_data;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, command, is_data, byte_value, input ready);
  modport sink (input valid, command, is_data, byte_value, output ready);
endinterface

interface clns_out_if import clns_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             pin_rs;
  logic             pin_rw;
  logic             pin_enable;
  logic [NIB_W-1:0] pin_nibble;
  logic             busy_res;
  logic             rejected;

  modport source (output valid, pin_rs, pin_rw, pin_enable, pin_nibble, busy_res,
                  rejected, input ready);
  modport sink (input valid, pin_rs, pin_rw, pin_enable, pin_nibble, busy_res,
                rejected, output ready);
endinterface

// ===== hw/rtl/char_lcd_nibble_sequencer_top.sv =====
// Character LCD 4-bit write sequencer: one input beat per time tick.
// An input beat passes the input register, then the result register, before its result
// beat is shown; one beat is taken every cycle while the output drains.
// Reset is synchronous and active low: timing registers return to defaults, the
// sequencer goes idle and both stages empty; the pin registers are not reset.
// Depends on clns_pkg, clns_if and assert_macros.svh.
`include "assert_macros.svh"

module char_lcd_nibble_sequencer_top import clns_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  clns_in_if.sink              in_ch,
  clns_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t              cfg_r;

  logic              s1_valid_r;
  logic [CMD_W-1:0]  s1_cmd_r;
  logic              s1_is_data_r;
  logic [BYTE_W-1:0] s1_byte_r;

  pos_t              pos_r;
  logic [STEP_W-1:0] step_r;
  logic [BYTE_W-1:0] hbyte_r;
  logic [NIB_W-1:0]  nib_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              sel_r;

  logic              out_valid_r;
  logic              rs_r;
  logic              en_r;
  logic [NIB_W-1:0]  nibble_r;
  logic              busy_r;
  logic              rej_r;

  logic              advance;
  logic              is_req;
  logic              rej_now;
  logic              sel_now;
  seq_state_t        now_st;
  seq_state_t        st_nxt;
  logic              en_now;
  logic              busy_now;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{setup: RST_SETUP, strobe: RST_STROBE, hold: RST_HOLD, gap: RST_GAP,
                 short_cmd: RST_SHORT, long_cmd: RST_LONG, power: RST_POWER};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETUP:  cfg_r.setup     <= cfg_wdata;
        REG_STROBE: cfg_r.strobe    <= cfg_wdata;
        REG_HOLD:   cfg_r.hold      <= cfg_wdata;
        REG_GAP:    cfg_r.gap       <= cfg_wdata;
        REG_SHORT:  cfg_r.short_cmd <= cfg_wdata;
        REG_LONG:   cfg_r.long_cmd  <= cfg_wdata;
        REG_POWER:  cfg_r.power     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_cmd_r     <= in_ch.command;
      s1_is_data_r <= in_ch.is_data;
      s1_byte_r    <= in_ch.byte_value;
    end
  end

  // The tick's request is applied first; the pins show that state.
  always_comb begin
    is_req  = (s1_cmd_r == CMD_WRITE) || (s1_cmd_r == CMD_INIT);
    rej_now = is_req && (pos_r != POS_IDLE);
    sel_now = sel_r;
    now_st  = '{pos: pos_r, step: step_r, hbyte: hbyte_r, nib: nib_r, cnt: cnt_r};
    if (is_req && (pos_r == POS_IDLE)) begin
      if (s1_cmd_r == CMD_WRITE) begin
        sel_now = s1_is_data_r;
        now_st  = seek(cfg_r, STEP_WRITE, POS_S1, s1_byte_r, s1_is_data_r);
      end else begin
        sel_now = 1'b0;
        if (cfg_r.power != '0) begin
          now_st = '{pos: POS_POWER, step: STEP_WRITE, hbyte: hbyte_r, nib: nib_r,
                     cnt: cfg_r.power};
        end else begin
          now_st = seek(cfg_r, STEP_FIRST, POS_S1, hbyte_r, 1'b0);
        end
      end
    end
  end

  // One tick of countdown, then on to the next phase when the count runs out.
  always_comb begin
    st_nxt = now_st;
    if (now_st.pos != POS_IDLE) begin
      if (now_st.cnt != CNT_W'(1)) begin
        st_nxt.cnt = now_st.cnt - CNT_W'(1);
      end else if (now_st.pos == POS_POWER) begin
        st_nxt = seek(cfg_r, STEP_FIRST, POS_S1, now_st.hbyte, sel_now);
      end else begin
        st_nxt = seek(cfg_r, now_st.step, next_entry(now_st.pos), now_st.hbyte, sel_now);
      end
    end
  end

  always_comb begin
    en_now   = (now_st.pos == POS_T1) || (now_st.pos == POS_T2);
    busy_now = now_st.pos != POS_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_IDLE;
      step_r      <= '0;
      hbyte_r     <= '0;
      nib_r       <= '0;
      cnt_r       <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        pos_r   <= st_nxt.pos;
        step_r  <= st_nxt.step;
        hbyte_r <= st_nxt.hbyte;
        nib_r   <= st_nxt.nib;
        cnt_r   <= st_nxt.cnt;
        sel_r   <= sel_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      rs_r     <= sel_now;
      en_r     <= en_now;
      nibble_r <= now_st.nib;
      busy_r   <= busy_now;
      rej_r    <= rej_now;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pin_rs     = rs_r;
  assign out_ch.pin_rw     = 1'b0;
  assign out_ch.pin_enable = en_r;
  assign out_ch.pin_nibble = nibble_r;
  assign out_ch.busy_res   = busy_r;
  assign out_ch.rejected   = rej_r;

  `ASSERT_ALWAYS(a_step_range, step_r <= STEP_LAST, "init step beyond last item")
  `ASSERT_IMPLIES(a_idle_clear, pos_r == POS_IDLE, (cnt_r == '0) && (step_r == '0), "idle with count or step left")
  `ASSERT_IMPLIES(a_busy_count, pos_r != POS_IDLE, cnt_r != '0, "busy phase with zero count")
  `ASSERT_IMPLIES(a_reject_busy, out_ch.valid && out_ch.rejected, out_ch.busy_res, "request rejected while idle")

endmodule
